// ===== design/sbsh_pkg.sv =====
// shared types, constants and round functions of the sha-256 byte stream hasher
package sbsh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HASH_W  = 256;
    localparam int unsigned BLOCK_W = 512;

    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_IDX   = 3'd7;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [HASH_W-1:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic       byte_en;
        logic [7:0] byte_val;
        logic       word_en;
    } sched_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } round_ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        unique case (t)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== design/sbsh_sched.sv =====
// block buffer and message schedule window of the sha-256 hasher
module sbsh_sched
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  sched_ctrl_t ctrl,
    output logic [31:0] w_out
);

    logic [BLOCK_W-1:0] window_reg;
    logic [BLOCK_W-1:0] window_next;
    logic [31:0]        w_new;

    // word t of the window sits at bits [511-32t -: 32]
    assign w_out = window_reg[511:480];
    assign w_new = ssig1(window_reg[63:32]) + window_reg[223:192]
                 + ssig0(window_reg[479:448]) + window_reg[511:480];

    always_comb begin
        priority if (ctrl.byte_en) begin
            window_next = {window_reg[BLOCK_W-9:0], ctrl.byte_val};
        end else if (ctrl.word_en) begin
            window_next = {window_reg[BLOCK_W-33:0], w_new};
        end else begin
            window_next = window_reg;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
    end

endmodule

// ===== design/sbsh_round.sv =====
// working variables and one-round compression unit of the sha-256 hasher
module sbsh_round
    import sbsh_pkg::*;
(
    input  logic              aclk,
    input  round_ctrl_t       ctrl,
    input  logic [HASH_W-1:0] hash_in,
    input  logic [31:0]       w_in,
    input  logic [31:0]       k_in,
    output logic [HASH_W-1:0] state_out
);

    logic [HASH_W-1:0] v_reg;
    logic [HASH_W-1:0] v_next;
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2;

    assign {a, b, c, d, e, f, g, h} = v_reg;
    assign state_out = v_reg;

    assign t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + k_in + w_in;
    assign t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));

    always_comb begin
        priority if (ctrl.load) begin
            v_next = hash_in;
        end else if (ctrl.step) begin
            v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
        end else begin
            v_next = v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

endmodule

// ===== design/sha256_byte_stream_hasher_top.sv =====
// top level of the sha-256 byte stream hasher: sequencer, chaining value and digest output
//
// input channel s_*: one word per message byte (s_tuser low) or a finish word
// (s_tuser high, s_tdata ignored); s_tready is high only while the block idles
// an absorbed byte shifts into the buffer; every 64th byte starts a compression of
// 64 rounds through the single round unit and then an update state that folds the
// result into the chaining value
// a finish writes the padding and the 64-bit length one byte a cycle, paused while
// a compression runs, with one or two compressions before the first digest word shows
// output channel m_*: eight digest words, index in m_tuser, m_tlast on the
// eighth; each word holds on the port until taken, and a stalled receiver
// simply holds the block in its output phase; no input is taken meanwhile
// after the eighth word the chaining value returns to the initial hash words
// reset (aresetn low, synchronous) loads the initial hash words, clears the
// byte count and bit length and leaves the block idle; the buffer needs none
module sha256_byte_stream_hasher_top
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    state_t            state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       bitlen_reg, bitlen_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [5:0]        round_reg, round_next;
    logic              pad_mode_reg, pad_mode_next;
    logic              pad_first_reg, pad_first_next;
    logic              len_phase_reg, len_phase_next;
    logic [2:0]        idx_reg, idx_next;

    sched_ctrl_t       sctrl;
    round_ctrl_t       rctrl;
    logic [31:0]       w_cur;
    logic [HASH_W-1:0] v_state;
    logic [31:0]       out_word;

    sbsh_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sctrl),
        .w_out (w_cur)
    );

    sbsh_round u_round (
        .aclk      (aclk),
        .ctrl      (rctrl),
        .hash_in   (hash_reg),
        .w_in      (w_cur),
        .k_in      (round_k(round_reg)),
        .state_out (v_state)
    );

    always_comb begin
        unique case (idx_reg)
            3'd0: out_word = hash_reg[255:224];
            3'd1: out_word = hash_reg[223:192];
            3'd2: out_word = hash_reg[191:160];
            3'd3: out_word = hash_reg[159:128];
            3'd4: out_word = hash_reg[127:96];
            3'd5: out_word = hash_reg[95:64];
            3'd6: out_word = hash_reg[63:32];
            3'd7: out_word = hash_reg[31:0];
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = out_word;
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == LAST_IDX);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        hash_next      = hash_reg;
        round_next     = round_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        idx_next       = idx_reg;
        sctrl.byte_en  = 1'b0;
        sctrl.byte_val = s_tdata;
        sctrl.word_en  = 1'b0;
        rctrl.load     = 1'b0;
        rctrl.step     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_DATA) begin
                        sctrl.byte_en = 1'b1;
                        bitlen_next   = bitlen_reg + BITS_PER_BYTE;
                    end else begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sctrl.byte_en = 1'b1;
                priority if (pad_first_reg) begin
                    sctrl.byte_val = PAD_BYTE;
                    pad_first_next = 1'b0;
                end else if (len_phase_reg || fill_reg == LEN_START) begin
                    sctrl.byte_val = bitlen_reg[63:56];
                    bitlen_next    = {bitlen_reg[55:0], 8'h00};
                    len_phase_next = 1'b1;
                end else begin
                    sctrl.byte_val = 8'h00;
                end
            end
            ST_ROUND: begin
                rctrl.step    = 1'b1;
                sctrl.word_en = 1'b1;
                round_next    = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[32*i +: 32] = hash_reg[32*i +: 32] + v_state[32*i +: 32];
                end
                priority if (pad_mode_reg && len_phase_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end else if (pad_mode_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == LAST_IDX) begin
                        hash_next      = HASH_IV;
                        pad_mode_next  = 1'b0;
                        len_phase_next = 1'b0;
                        idx_next       = 3'd0;
                        state_next     = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a full buffer hands over to the round unit
        if (sctrl.byte_en) begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_BYTE) begin
                rctrl.load = 1'b1;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bitlen_reg    <= 64'd0;
            hash_reg      <= HASH_IV;
            round_reg     <= 6'd0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bitlen_reg    <= bitlen_next;
            hash_reg      <= hash_next;
            round_reg     <= round_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

// ===== design/sbsh_checker.sv =====
// port-level checks of the sha-256 hasher and their binding to the top level
module sbsh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // stalled output word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    // no input taken while the digest is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during digest output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("last flag out of step with word index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1)))
        else $error("digest word sequence broken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block not idle after final digest word");

endmodule

bind sha256_byte_stream_hasher_top sbsh_checker u_sbsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
